/* design/lsp_pkg.sv */
// Package: shared constants, types and codes of the line sensor position unit.
`default_nettype none
package lsp_pkg;
  localparam int MaxSensors = 8;
  localparam int DefSensorCount = 8;
  localparam int DefFilterDepth = 8;
  localparam int SampleW = 12;
  localparam int NormW = 10;
  localparam int WeightW = 16;
  localparam logic [SampleW-1:0] FullScale = 12'd4095;
  localparam logic [NormW-1:0] NormMax = 10'd1000;

  typedef enum logic [1:0] {
    FUNC_SCAN = 2'd0,
    FUNC_CAL = 2'd1,
    FUNC_RST_BOUNDS = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  typedef logic signed [WeightW-1:0] weight_arr_t [MaxSensors];

  function automatic logic signed [WeightW-1:0] weight_reset(input int i);
    case (i)
      0: weight_reset = -16'sd896;
      1: weight_reset = -16'sd640;
      2: weight_reset = -16'sd384;
      3: weight_reset = -16'sd128;
      4: weight_reset = 16'sd128;
      5: weight_reset = 16'sd384;
      6: weight_reset = 16'sd640;
      default: weight_reset = 16'sd896;
    endcase
  endfunction
endpackage
`default_nettype wire

/* design/lsp_if.sv */
// Interfaces: scan input, result output and register write channels.
`default_nettype none
interface lsp_in_if;
  logic valid;
  logic ready;
  logic [1:0] func;
  logic [11:0] sample [8];
  modport source(output valid, func, sample, input ready);
  modport sink(input valid, func, sample, output ready);
endinterface

interface lsp_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] position;
  logic line_seen;
  logic [9:0] norm [8];
  modport source(output valid, position, line_seen, norm, input ready);
  modport sink(input valid, position, line_seen, norm, output ready);
endinterface

interface lsp_cfg_if;
  logic valid;
  logic ready;
  logic [3:0] index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/line_sensor_position_unit.sv */
// Top level: line sensor filter, calibration, normalization and centroid.
// Usage: scans enter on in_ch (func plus eight samples). Codes scan,
// calibration scan and reset bounds give no result; a query gives one
// result on out_ch with the position, line_seen and eight norms.
// Weights on cfg_ch (index 0..7, others ignored) are to be written by the
// user only while idle; the block itself does not enforce this. Scan codes
// write one ring entry per cycle through the history memory write port, no
// read needed; reset bounds completes in the idle state. A query, for each
// sensor, sums its ring entries, sets up (S_PREP) a pass of a shared
// restoring divider, then clamps (S_FIN) and accumulates (S_ACC); a signed
// division for the centroid follows on the same divider, and the result is
// then held in S_OUT. The division is skipped for a sensor whose norm is
// forced to zero.
// Reset clears weights to their defaults, bounds to 4095/0, and runs a
// clearing pass over all SENSOR_COUNT*FILTER_DEPTH history entries,
// during which no scan is accepted.
// The result register holds while the receiver stalls; the next item is
// accepted only after it is transferred.
`default_nettype none
module line_sensor_position_unit
  import lsp_pkg::*;
#(
  parameter int SENSOR_COUNT = DefSensorCount,
  parameter int FILTER_DEPTH = DefFilterDepth
) (
  input wire clk,
  input wire rst,
  lsp_in_if.sink in_ch,
  lsp_out_if.source out_ch,
  lsp_cfg_if.sink cfg_ch
);
  localparam int Depth = SENSOR_COUNT * FILTER_DEPTH;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int SW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int SumW = SampleW + 7;
  localparam int NumW = SumW + 10;
  localparam int DW = 40;
  localparam int CW = 6;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_WRITE = 10'b0000000100,
    S_SUM = 10'b0000001000,
    S_PREP = 10'b0000010000,
    S_DIV = 10'b0000100000,
    S_ACC = 10'b0001000000,
    S_CDIV = 10'b0010000000,
    S_FIN = 10'b0100000000,
    S_OUT = 10'b1000000000
  } state_t;

  state_t state;
  logic [SampleW-1:0] mem [Depth];
  logic [SampleW-1:0] rdata;
  logic [AW-1:0] waddr, raddr;
  logic [SampleW-1:0] wdata;
  logic we;
  logic [AW:0] clr_cnt;
  logic [PW-1:0] ring_ptr;
  logic [SW-1:0] sidx;
  logic [PW:0] kcnt;
  logic rvalid;
  logic [SampleW-1:0] samp [MaxSensors];
  logic [SampleW-1:0] low_b [MaxSensors];
  logic [SampleW-1:0] high_b [MaxSensors];
  weight_arr_t weight;
  logic [SumW-1:0] acc;
  // shared divider
  logic [DW-1:0] rem, divisor;
  logic [DW-1:0] quo;
  logic [CW-1:0] dcnt;
  logic neg;
  logic signed [39:0] wsum;
  logic [13:0] vsum;
  logic [NormW-1:0] norm [MaxSensors];
  logic signed [15:0] position;
  logic line_seen;

  assign in_ch.ready = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.position = position;
  assign out_ch.line_seen = line_seen;
  always_comb begin
    for (int i = 0; i < MaxSensors; i++) out_ch.norm[i] = norm[i];
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_cnt[AW-1:0];
    end else if (state == S_WRITE) begin
      we = 1'b1;
      waddr = AW'(int'(sidx) * FILTER_DEPTH + int'(ring_ptr));
      wdata = samp[sidx];
    end
  end
  assign raddr = AW'(int'(sidx) * FILTER_DEPTH + int'(kcnt[PW-1:0]));

  logic [DW:0] trial;
  assign trial = {1'b0, rem[DW-2:0], quo[DW-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      ring_ptr <= '0;
      sidx <= '0;
      kcnt <= '0;
      rvalid <= 1'b0;
      for (int i = 0; i < MaxSensors; i++) begin
        low_b[i] <= FullScale;
        high_b[i] <= '0;
        weight[i] <= weight_reset(i);
        norm[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid && cfg_ch.index < 4'(MaxSensors))
        weight[cfg_ch.index[2:0]] <= cfg_ch.data;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(Depth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            for (int i = 0; i < MaxSensors; i++) begin
              samp[i] <= in_ch.sample[i];
              norm[i] <= '0;
            end
            sidx <= '0;
            kcnt <= '0;
            rvalid <= 1'b0;
            acc <= '0;
            wsum <= '0;
            vsum <= '0;
            case (func_t'(in_ch.func))
              FUNC_SCAN: state <= S_WRITE;
              FUNC_CAL: begin
                state <= S_WRITE;
                for (int i = 0; i < SENSOR_COUNT; i++) begin
                  if (in_ch.sample[i] < low_b[i]) low_b[i] <= in_ch.sample[i];
                  if (in_ch.sample[i] > high_b[i]) high_b[i] <= in_ch.sample[i];
                end
              end
              FUNC_RST_BOUNDS: begin
                for (int i = 0; i < MaxSensors; i++) begin
                  low_b[i] <= FullScale;
                  high_b[i] <= '0;
                end
              end
              default: state <= S_SUM;
            endcase
          end
        end
        S_WRITE: begin
          if (sidx == SW'(SENSOR_COUNT - 1)) begin
            sidx <= '0;
            ring_ptr <= (ring_ptr == PW'(FILTER_DEPTH - 1)) ? '0 : ring_ptr + 1'b1;
            state <= S_IDLE;
          end else sidx <= sidx + 1'b1;
        end
        S_SUM: begin
          rvalid <= (kcnt < (PW+1)'(FILTER_DEPTH));
          if (kcnt < (PW+1)'(FILTER_DEPTH)) kcnt <= kcnt + 1'b1;
          if (rvalid) acc <= acc + SumW'(rdata);
          if (!rvalid && kcnt == (PW+1)'(FILTER_DEPTH)) state <= S_PREP;
        end
        S_PREP: begin
          // numerator (sum - low*D)*1000, divisor D*(high-low)
          quo <= DW'((NumW)'(acc - SumW'(low_b[sidx] * FILTER_DEPTH)) * 10'd1000)
                 << (DW - NumW);
          divisor <= DW'(SumW'((high_b[sidx] - low_b[sidx])) * FILTER_DEPTH);
          rem <= '0;
          dcnt <= CW'(NumW);
          if (high_b[sidx] <= low_b[sidx] ||
              acc <= SumW'(low_b[sidx] * FILTER_DEPTH)) begin
            norm[sidx] <= '0;
            state <= S_ACC;
          end else state <= S_DIV;
        end
        S_DIV: begin
          if (!trial[DW]) begin
            rem <= trial[DW-1:0];
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= {rem[DW-2:0], quo[DW-1]};
            quo <= {quo[DW-2:0], 1'b0};
          end
          dcnt <= dcnt - 1'b1;
          if (dcnt == CW'(1)) state <= S_FIN;
        end
        S_FIN: begin
          if (neg) begin
            position <= wsum[39] ? -quo[15:0] : quo[15:0];
            line_seen <= 1'b1;
            state <= S_OUT;
          end else begin
            norm[sidx] <= (quo > DW'(NormMax)) ? NormMax : quo[NormW-1:0];
            state <= S_ACC;
          end
        end
        S_ACC: begin
          wsum <= wsum + 40'(signed'({1'b0, norm[sidx]})) * 40'(weight[sidx]);
          vsum <= vsum + 14'(norm[sidx]);
          kcnt <= '0;
          rvalid <= 1'b0;
          acc <= '0;
          if (sidx == SW'(SENSOR_COUNT - 1)) state <= S_CDIV;
          else begin
            sidx <= sidx + 1'b1;
            state <= S_SUM;
          end
        end
        S_CDIV: begin
          if (vsum == '0) begin
            position <= '0;
            line_seen <= 1'b0;
            state <= S_OUT;
          end else begin
            quo <= (wsum[39] ? -wsum : wsum) << (DW - NumW);
            divisor <= DW'(vsum);
            rem <= '0;
            dcnt <= CW'(NumW);
            state <= S_DIV;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // neg flags the centroid division pass
  always_ff @(posedge clk) begin
    if (rst) neg <= 1'b0;
    else if (state == S_IDLE) neg <= 1'b0;
    else if (state == S_CDIV) neg <= 1'b1;
  end
endmodule
`default_nettype wire

/* sim/lsp_checker.sv */
// Checker: watches the scan, result and register channels, predicts results and compares them.
module lsp_checker
  import lsp_pkg::*;
(
  input wire clk,
  input wire rst,
  lsp_in_if in_ch,
  lsp_out_if out_ch,
  lsp_cfg_if cfg_ch,
  output int fail_count,
  output int pending,
  output int query_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] position;
    logic line_seen;
    logic [7:0][9:0] norm;
  } centroid_t;

  centroid_t centroid_q[$];
  logic signed [15:0] wt [8];
  logic [11:0] hist [8][8];
  logic [2:0] slot;
  logic [11:0] lo [8];
  logic [11:0] hi [8];

  function automatic logic [9:0] level_norm(input int s);
    longint sum, base, q;
    sum = 0;
    if (hi[s] <= lo[s]) return 0;
    for (int k = 0; k < 8; k++) sum += hist[s][k];
    base = longint'(lo[s]) * 8;
    if (sum <= base) return 0;
    q = ((sum - base) * 1000) / (longint'(hi[s] - lo[s]) * 8);
    return (q > 1000) ? 10'd1000 : 10'(q);
  endfunction

  function automatic centroid_t predict_centroid();
    centroid_t r;
    longint ws, vs, p;
    ws = 0;
    vs = 0;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      r.norm[i] = level_norm(i);
      ws += longint'(r.norm[i]) * longint'(wt[i]);
      vs += r.norm[i];
    end
    if (vs > 0) p = ws / vs;
    r.position = 16'(p);
    r.line_seen = (vs > 0);
    return r;
  endfunction

  assign pending = centroid_q.size();

  always @(posedge clk) begin
    centroid_t e;
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        wt[i] = weight_reset(i);
        lo[i] = 12'd4095;
        hi[i] = 0;
        for (int k = 0; k < 8; k++) hist[i][k] = 0;
      end
      slot = 0;
      fail_count = 0;
      query_count = 0;
      centroid_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < 8) wt[cfg_ch.index] = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        case (func_t'(in_ch.func))
          FUNC_SCAN, FUNC_CAL: begin
            for (int i = 0; i < 8; i++) begin
              hist[i][slot] = in_ch.sample[i];
              if (in_ch.func == FUNC_CAL) begin
                if (in_ch.sample[i] < lo[i]) lo[i] = in_ch.sample[i];
                if (in_ch.sample[i] > hi[i]) hi[i] = in_ch.sample[i];
              end
            end
            slot = slot + 3'd1;
          end
          FUNC_RST_BOUNDS: begin
            for (int i = 0; i < 8; i++) begin
              lo[i] = 12'd4095;
              hi[i] = 0;
            end
          end
          default: centroid_q.push_back(predict_centroid());
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        query_count++;
        if (centroid_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer");
        end else begin
          e = centroid_q.pop_front();
          if (e.position !== out_ch.position || e.line_seen !== out_ch.line_seen
              || e.norm !== {out_ch.norm[7], out_ch.norm[6], out_ch.norm[5], out_ch.norm[4],
                             out_ch.norm[3], out_ch.norm[2], out_ch.norm[1], out_ch.norm[0]})
          begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp pos %0d seen %0b norms %p, got pos %0d seen %0b norms %p",
                       e.position, e.line_seen, e.norm, out_ch.position, out_ch.line_seen,
                       out_ch.norm);
          end
        end
      end
    end
  end
endmodule

/* sim/tb_line_sensor_position_unit.sv */
// Testbench top: clock, reset, stimulus, register writes, stalls and verdict.
module tb_line_sensor_position_unit;
  import lsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Watchdog = 20000;

  logic clk = 0;
  logic rst = 1;
  int fail_count, pending, query_count, idle_cycles, scans_sent;
  bit calm;

  lsp_in_if in_ch();
  lsp_out_if out_ch();
  lsp_cfg_if cfg_ch();

  line_sensor_position_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );
  lsp_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending), .query_count(query_count)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.func = FUNC_SCAN;
    for (int i = 0; i < 8; i++) in_ch.sample[i] = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = 0;
    cfg_ch.data = 0;
  end

  always @(posedge clk) begin
    if (rst || in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready
        || cfg_ch.valid && cfg_ch.ready)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= Watchdog) begin
      $display("line_sensor_position_unit verification failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 3) != 0) out_ch.ready <= 1;
      else begin
        n = $urandom_range(1, 19);
        out_ch.ready <= 0;
        repeat (n) @(negedge clk);
        out_ch.ready <= 1;
      end
    end
  end

  task automatic send_scan(input func_t f, input logic [11:0] s [8]);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.func <= f;
    for (int i = 0; i < 8; i++) in_ch.sample[i] <= s[i];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scans_sent++;
  endtask

  task automatic send_flat(input func_t f, input logic [11:0] v);
    logic [11:0] s [8];
    for (int i = 0; i < 8; i++) s[i] = v;
    send_scan(f, s);
  endtask

  task automatic send_random(input func_t f, input int lo_v, input int hi_v);
    logic [11:0] s [8];
    for (int i = 0; i < 8; i++) s[i] = 12'($urandom_range(lo_v, hi_v));
    send_scan(f, s);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  task automatic write_weight(input logic [3:0] idx, input logic [15:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  initial begin
    int r;
    logic [11:0] s [8];
    repeat (5) @(negedge clk);
    rst <= 0;
    // directed
    send_flat(FUNC_QUERY, 12'hFFF);
    send_flat(FUNC_CAL, 12'd0);
    send_flat(FUNC_CAL, 12'hFFF);
    send_flat(FUNC_QUERY, 0);
    for (int i = 0; i < 8; i++) s[i] = 12'hFFF;
    for (int k = 0; k < 8; k++) send_scan(FUNC_SCAN, s);
    send_flat(FUNC_QUERY, 0);
    send_flat(FUNC_CAL, 12'd2000);
    for (int i = 0; i < 8; i++) s[i] = (i % 2) ? 12'hAAA : 12'h555;
    send_scan(FUNC_CAL, s);
    send_flat(FUNC_SCAN, 12'd0);
    send_flat(FUNC_QUERY, 0);
    send_flat(FUNC_RST_BOUNDS, 12'hFFF);
    send_flat(FUNC_QUERY, 0);
    send_random(FUNC_CAL, 100, 300);
    send_random(FUNC_CAL, 3000, 3500);
    send_flat(FUNC_SCAN, 12'd50);
    send_flat(FUNC_QUERY, 0);
    // random phases with different weight settings
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      for (int i = 0; i < 9; i++) begin
        case (ph)
          0: write_weight(4'(i), 16'h8000);
          1: write_weight(4'(i), 16'h7FFF);
          2: write_weight(4'(i), (i % 2) ? 16'h7FFF : 16'h8000);
          default: write_weight(4'(i), 16'($urandom_range(0, 16'hFFFF)));
        endcase
      end
      write_weight(4'd15, 16'($urandom_range(0, 16'hFFFF)));
      @(negedge clk);
      cfg_ch.valid <= 0;
      if (ph == 5) calm = 1;
      for (int n = 0; n < 105; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4) send_random(FUNC_RST_BOUNDS, 0, 4095);
        else if (r < 25) send_random(FUNC_CAL, 0, 4095);
        else if (r < 35) send_random(FUNC_CAL, 1000, 3000);
        else if (r < 65) send_random(FUNC_SCAN, 0, 4095);
        else send_random(FUNC_QUERY, 0, 4095);
      end
    end
    drain();
    $display("sent %0d scans including queries; %0d results checked over 6 weight settings",
             scans_sent, query_count);
    if (fail_count == 0) $display("line_sensor_position_unit verification clean");
    else $display("line_sensor_position_unit verification failed");
    $finish;
  end
endmodule
